FILE: sv/eau_pkg.sv
// shared types, codes and helpers of the effective address unit
package eau_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic CMD_WRITE = 1'b0;

  localparam logic [2:0] MODE_DN     = 3'd0;
  localparam logic [2:0] MODE_AN     = 3'd1;
  localparam logic [2:0] MODE_IND    = 3'd2;
  localparam logic [2:0] MODE_POSTINC = 3'd3;
  localparam logic [2:0] MODE_PREDEC = 3'd4;
  localparam logic [2:0] MODE_DISP   = 3'd5;
  localparam logic [2:0] MODE_INDEX  = 3'd6;
  localparam logic [2:0] MODE_EXT    = 3'd7;

  localparam logic [2:0] SUB_ABSW    = 3'd0;
  localparam logic [2:0] SUB_ABSL    = 3'd1;
  localparam logic [2:0] SUB_PCDISP  = 3'd2;
  localparam logic [2:0] SUB_PCINDEX = 3'd3;
  localparam logic [2:0] SUB_IMM     = 3'd4;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;
  localparam logic [1:0] SIZE_NONE = 2'd3;

  typedef enum logic [2:0] {
    ST_MEM   = 3'd0,
    ST_REG   = 3'd1,
    ST_IMM   = 3'd2,
    ST_UNSUP = 3'd3,
    ST_FAULT = 3'd4,
    ST_SIZE  = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    KIND_WRITE,
    KIND_DONE,
    KIND_IND,
    KIND_POSTINC,
    KIND_PREDEC,
    KIND_DISP,
    KIND_INDEX,
    KIND_ABSW,
    KIND_ABSL,
    KIND_PCDISP,
    KIND_PCINDEX,
    KIND_IMM
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [1:0]  size;
    logic [3:0]  reg_a;
    logic [3:0]  reg_x;
    logic [31:0] data;
    logic [31:0] pc;
    logic [31:0] ext;
  } op_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] address;
    logic [31:0] immediate;
    logic [2:0]  ext_bytes;
  } res_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } head_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    sext16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sext8(input logic [7:0] v);
    sext8 = {{24{v[7]}}, v};
  endfunction

endpackage

FILE: sv/eau_front.sv
// front end: classifies incoming beats and queues them for execution
module eau_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic              cmd_i,
  input  logic [3:0]        write_index_i,
  input  logic [31:0]       write_value_i,
  input  logic [2:0]        ea_mode_i,
  input  logic [2:0]        ea_reg_i,
  input  logic [1:0]        operand_size_i,
  input  logic [31:0]       pc_value_i,
  input  logic [31:0]       ext_words_i,
  input  logic              fetch_fault_i,
  output eau_pkg::head_t    head_o,
  input  logic              take_i
);

  eau_pkg::op_t  op_d;
  eau_pkg::op_t  q_mem_q [eau_pkg::QDEPTH];
  eau_pkg::ptr_t wr_ptr_q, rd_ptr_q;
  eau_pkg::cnt_t count_q;
  logic          push, pop;

  always_comb begin
    op_d        = '0;
    op_d.kind   = eau_pkg::KIND_DONE;
    op_d.status = eau_pkg::ST_MEM;
    op_d.size   = operand_size_i;
    op_d.reg_a  = {1'b1, ea_reg_i};
    op_d.reg_x  = {ext_words_i[31], ext_words_i[30:28]};
    op_d.data   = write_value_i;
    op_d.pc     = pc_value_i;
    op_d.ext    = ext_words_i;
    if (cmd_i == eau_pkg::CMD_WRITE) begin
      op_d.kind  = eau_pkg::KIND_WRITE;
      op_d.reg_a = write_index_i;
    end else begin
      case (ea_mode_i)
        eau_pkg::MODE_DN, eau_pkg::MODE_AN: begin
          op_d.status = eau_pkg::ST_REG;
        end
        eau_pkg::MODE_IND: begin
          op_d.kind = eau_pkg::KIND_IND;
        end
        eau_pkg::MODE_POSTINC: begin
          if (operand_size_i == eau_pkg::SIZE_NONE) op_d.status = eau_pkg::ST_SIZE;
          else op_d.kind = eau_pkg::KIND_POSTINC;
        end
        eau_pkg::MODE_PREDEC: begin
          if (operand_size_i == eau_pkg::SIZE_NONE) op_d.status = eau_pkg::ST_SIZE;
          else op_d.kind = eau_pkg::KIND_PREDEC;
        end
        eau_pkg::MODE_DISP: begin
          if (fetch_fault_i) op_d.status = eau_pkg::ST_FAULT;
          else op_d.kind = eau_pkg::KIND_DISP;
        end
        eau_pkg::MODE_INDEX: begin
          if (fetch_fault_i) op_d.status = eau_pkg::ST_FAULT;
          else op_d.kind = eau_pkg::KIND_INDEX;
        end
        default: begin
          if (ea_reg_i > eau_pkg::SUB_IMM) begin
            op_d.status = eau_pkg::ST_UNSUP;
          end else if (ea_reg_i == eau_pkg::SUB_IMM &&
                       operand_size_i == eau_pkg::SIZE_NONE) begin
            op_d.status = eau_pkg::ST_SIZE;
          end else if (fetch_fault_i) begin
            op_d.status = eau_pkg::ST_FAULT;
          end else begin
            case (ea_reg_i)
              eau_pkg::SUB_ABSW:    op_d.kind = eau_pkg::KIND_ABSW;
              eau_pkg::SUB_ABSL:    op_d.kind = eau_pkg::KIND_ABSL;
              eau_pkg::SUB_PCDISP:  op_d.kind = eau_pkg::KIND_PCDISP;
              eau_pkg::SUB_PCINDEX: op_d.kind = eau_pkg::KIND_PCINDEX;
              default:              op_d.kind = eau_pkg::KIND_IMM;
            endcase
          end
        end
      endcase
    end
  end

  assign full_o      = (count_q == eau_pkg::cnt_t'(eau_pkg::QDEPTH));
  assign push        = push_i && !full_o;
  assign pop         = take_i && head_o.valid;
  assign head_o.valid = (count_q != '0);
  assign head_o.op    = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_ptr_q] <= op_d;
  end

endmodule

FILE: sv/eau_back.sv
// back end: register file, address arithmetic and result queue
module eau_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  eau_pkg::head_t head_i,
  output logic           take_o,
  output logic           empty_o,
  input  logic           pop_i,
  output eau_pkg::res_t  res_o
);

  logic [31:0]   mem_q [16];
  logic [15:0]   valid_q;

  logic          x_valid_q, x_fire;
  eau_pkg::op_t  x_op_q;
  logic [31:0]   rda_q, rdx_q;
  logic          va_q, vx_q;
  logic          fwd_valid_q;
  logic [3:0]    fwd_addr_q;
  logic [31:0]   fwd_data_q;

  logic          wr_en;
  logic [3:0]    wr_addr;
  logic [31:0]   wr_data;
  logic [31:0]   a_val, x_val, idx, step, w0s, d8;
  eau_pkg::res_t res_d;

  eau_pkg::res_t res_mem_q [eau_pkg::QDEPTH];
  eau_pkg::ptr_t wr_ptr_q, rd_ptr_q;
  eau_pkg::cnt_t count_q;
  logic          res_full, res_pop;

  assign res_full = (count_q == eau_pkg::cnt_t'(eau_pkg::QDEPTH));
  assign x_fire   = x_valid_q && !res_full;
  assign take_o   = head_i.valid && (!x_valid_q || x_fire);
  assign empty_o  = (count_q == '0);
  assign res_pop  = pop_i && !empty_o;
  assign res_o    = res_mem_q[rd_ptr_q];

  // operands with bypass of the write made as they were read
  always_comb begin
    if (fwd_valid_q && fwd_addr_q == x_op_q.reg_a) a_val = fwd_data_q;
    else a_val = va_q ? rda_q : '0;
    if (fwd_valid_q && fwd_addr_q == x_op_q.reg_x) x_val = fwd_data_q;
    else x_val = vx_q ? rdx_q : '0;
  end

  always_comb begin
    idx  = x_op_q.ext[27] ? x_val : eau_pkg::sext16(x_val[15:0]);
    d8   = eau_pkg::sext8(x_op_q.ext[23:16]);
    w0s  = eau_pkg::sext16(x_op_q.ext[31:16]);
    case (x_op_q.size)
      eau_pkg::SIZE_BYTE: step = 32'd1;
      eau_pkg::SIZE_WORD: step = 32'd2;
      default:            step = 32'd4;
    endcase
  end

  always_comb begin
    res_d        = '0;
    res_d.status = eau_pkg::ST_MEM;
    wr_en        = 1'b0;
    wr_addr      = x_op_q.reg_a;
    wr_data      = x_op_q.data;
    case (x_op_q.kind)
      eau_pkg::KIND_WRITE: begin
        wr_en = 1'b1;
      end
      eau_pkg::KIND_DONE: begin
        res_d.status = x_op_q.status;
      end
      eau_pkg::KIND_IND: begin
        res_d.address = a_val;
      end
      eau_pkg::KIND_POSTINC: begin
        res_d.address = a_val;
        wr_en         = 1'b1;
        wr_data       = a_val + step;
      end
      eau_pkg::KIND_PREDEC: begin
        wr_en         = 1'b1;
        wr_data       = a_val - step;
        res_d.address = wr_data;
      end
      eau_pkg::KIND_DISP: begin
        res_d.address   = a_val + w0s;
        res_d.ext_bytes = 3'd2;
      end
      eau_pkg::KIND_INDEX: begin
        res_d.address   = a_val + d8 + idx;
        res_d.ext_bytes = 3'd2;
      end
      eau_pkg::KIND_ABSW: begin
        res_d.address   = w0s;
        res_d.ext_bytes = 3'd2;
      end
      eau_pkg::KIND_ABSL: begin
        res_d.address   = x_op_q.ext;
        res_d.ext_bytes = 3'd4;
      end
      eau_pkg::KIND_PCDISP: begin
        res_d.address   = x_op_q.pc + w0s;
        res_d.ext_bytes = 3'd2;
      end
      eau_pkg::KIND_PCINDEX: begin
        res_d.address   = x_op_q.pc + d8 + idx;
        res_d.ext_bytes = 3'd2;
      end
      eau_pkg::KIND_IMM: begin
        res_d.status = eau_pkg::ST_IMM;
        case (x_op_q.size)
          eau_pkg::SIZE_BYTE: begin
            res_d.immediate = {24'd0, x_op_q.ext[23:16]};
            res_d.ext_bytes = 3'd2;
          end
          eau_pkg::SIZE_WORD: begin
            res_d.immediate = {16'd0, x_op_q.ext[31:16]};
            res_d.ext_bytes = 3'd2;
          end
          default: begin
            res_d.immediate = x_op_q.ext;
            res_d.ext_bytes = 3'd4;
          end
        endcase
      end
      default: begin
        res_d.status = eau_pkg::ST_UNSUP;
      end
    endcase
    wr_en = wr_en && x_fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q   <= 1'b0;
      fwd_valid_q <= 1'b0;
      valid_q     <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
    end else begin
      if (take_o) begin
        x_valid_q   <= 1'b1;
        fwd_valid_q <= wr_en;
      end else if (x_fire) begin
        x_valid_q <= 1'b0;
      end
      if (wr_en) valid_q[wr_addr] <= 1'b1;
      if (x_fire) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (res_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (x_fire && !res_pop) count_q <= count_q + 1'b1;
      else if (res_pop && !x_fire) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      x_op_q     <= head_i.op;
      rda_q      <= mem_q[head_i.op.reg_a];
      rdx_q      <= mem_q[head_i.op.reg_x];
      va_q       <= valid_q[head_i.op.reg_a];
      vx_q       <= valid_q[head_i.op.reg_x];
      fwd_addr_q <= wr_addr;
      fwd_data_q <= wr_data;
    end
    if (x_fire) res_mem_q[wr_ptr_q] <= res_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= eau_pkg::cnt_t'(eau_pkg::QDEPTH))
    else $error("result queue overflow");

  a_write_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> valid_q[$past(wr_addr)])
    else $error("written register not marked valid");

  a_fire_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_fire && !res_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("finished beat lost");

  a_no_take_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_valid_q && res_full) |-> !take_o)
    else $error("stalled beat overwritten");

endmodule

FILE: sv/effective_address_unit.sv
// top level of the effective address unit
// Sixteen-register 68000-style effective address unit with queue ports on both sides.
// One beat is accepted per cycle while full is low, and one result is produced per
// beat, in order; a register write also yields an all-zero result. From accept to
// result a beat passes through the front queue, then the execute stage, whose
// registered register-file read feeds the address add that writes the result queue;
// the result then waits until popped. Throughput is one beat per cycle while pop
// keeps up; each side has a two-entry queue. Writes from one beat are bypassed to
// the next, so postincrement, predecrement and register writes take effect for the
// very next beat. All registers read as zero after reset.
module effective_address_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        cmd_i,
  input  logic [3:0]  write_index_i,
  input  logic [31:0] write_value_i,
  input  logic [2:0]  ea_mode_i,
  input  logic [2:0]  ea_reg_i,
  input  logic [1:0]  operand_size_i,
  input  logic [31:0] pc_value_i,
  input  logic [31:0] ext_words_i,
  input  logic        fetch_fault_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [31:0] address_o,
  output logic [31:0] immediate_o,
  output logic [2:0]  ext_bytes_o
);

  eau_pkg::head_t head;
  eau_pkg::res_t  res;
  logic           take;

  eau_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .cmd_i          (cmd_i),
    .write_index_i  (write_index_i),
    .write_value_i  (write_value_i),
    .ea_mode_i      (ea_mode_i),
    .ea_reg_i       (ea_reg_i),
    .operand_size_i (operand_size_i),
    .pc_value_i     (pc_value_i),
    .ext_words_i    (ext_words_i),
    .fetch_fault_i  (fetch_fault_i),
    .head_o         (head),
    .take_i         (take)
  );

  eau_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .take_o  (take),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (res)
  );

  assign status_o    = res.status;
  assign address_o   = res.address;
  assign immediate_o = res.immediate;
  assign ext_bytes_o = res.ext_bytes;

endmodule

FILE: tb/testbench.sv
// testbench of the effective address unit: directed table then random beats, checked by a predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  SIZE_LONG = 2'd2;
  localparam logic        CMD_EA    = 1'b1;
  localparam int unsigned N_RANDOM  = 1000;

  typedef struct {
    logic        cmd;
    logic [3:0]  widx;
    logic [31:0] wval;
    logic [2:0]  mode;
    logic [2:0]  ea_reg;
    logic [1:0]  size;
    logic [31:0] pc;
    logic [31:0] ext;
    logic        fault;
  } ea_item_t;

  typedef struct {
    ea_item_t      item;
    bit            fixed;
    eau_pkg::res_t want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic        cmd_i;
  logic [3:0]  write_index_i;
  logic [31:0] write_value_i;
  logic [2:0]  ea_mode_i;
  logic [2:0]  ea_reg_i;
  logic [1:0]  operand_size_i;
  logic [31:0] pc_value_i;
  logic [31:0] ext_words_i;
  logic        fetch_fault_i;
  logic        empty;
  logic        pop;
  logic [2:0]  status_o;
  logic [31:0] address_o;
  logic [31:0] immediate_o;
  logic [2:0]  ext_bytes_o;

  logic [31:0]   gpr [16];
  eau_pkg::res_t pending_q [$];
  stim_row_t     rows [$];
  int unsigned   err_count;
  bit            tx_burst;
  bit            rx_burst;
  bit            hold_off_req;

  effective_address_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .cmd_i          (cmd_i),
    .write_index_i  (write_index_i),
    .write_value_i  (write_value_i),
    .ea_mode_i      (ea_mode_i),
    .ea_reg_i       (ea_reg_i),
    .operand_size_i (operand_size_i),
    .pc_value_i     (pc_value_i),
    .ext_words_i    (ext_words_i),
    .fetch_fault_i  (fetch_fault_i),
    .empty          (empty),
    .pop            (pop),
    .status_o       (status_o),
    .address_o      (address_o),
    .immediate_o    (immediate_o),
    .ext_bytes_o    (ext_bytes_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // base + d8 + index register from a brief extension word
  function automatic logic [31:0] index_sum(input logic [31:0] base, input logic [15:0] brief);
    logic [31:0] xn;
    xn = gpr[{brief[15], brief[14:12]}];
    if (!brief[11]) xn = {{16{xn[15]}}, xn[15:0]};
    return base + {{24{brief[7]}}, brief[7:0]} + xn;
  endfunction

  function automatic eau_pkg::res_t predict_ea(input ea_item_t it);
    eau_pkg::res_t r;
    logic [3:0]    ai;
    logic [15:0]   w0;
    logic [31:0]   w0x;
    logic [31:0]   step;
    r = '0;
    ai = {1'b1, it.ea_reg};
    w0 = it.ext[31:16];
    w0x = {{16{w0[15]}}, w0};
    step = (it.size == eau_pkg::SIZE_BYTE) ? 32'd1 :
           (it.size == eau_pkg::SIZE_WORD) ? 32'd2 : 32'd4;
    if (it.cmd == eau_pkg::CMD_WRITE) begin
      gpr[it.widx] = it.wval;
      return r;
    end
    case (it.mode)
      eau_pkg::MODE_DN, eau_pkg::MODE_AN: r.status = eau_pkg::ST_REG;
      eau_pkg::MODE_IND: r.address = gpr[ai];
      eau_pkg::MODE_POSTINC: begin
        if (it.size == eau_pkg::SIZE_NONE) begin
          r.status = eau_pkg::ST_SIZE;
        end else begin
          r.address = gpr[ai];
          gpr[ai] = gpr[ai] + step;
        end
      end
      eau_pkg::MODE_PREDEC: begin
        if (it.size == eau_pkg::SIZE_NONE) begin
          r.status = eau_pkg::ST_SIZE;
        end else begin
          gpr[ai] = gpr[ai] - step;
          r.address = gpr[ai];
        end
      end
      eau_pkg::MODE_DISP, eau_pkg::MODE_INDEX: begin
        if (it.fault) begin
          r.status = eau_pkg::ST_FAULT;
        end else begin
          r.address = (it.mode == eau_pkg::MODE_DISP) ? gpr[ai] + w0x :
                      index_sum(gpr[ai], w0);
          r.ext_bytes = 3'd2;
        end
      end
      default: begin
        if (it.ea_reg > eau_pkg::SUB_IMM) begin
          r.status = eau_pkg::ST_UNSUP;
        end else if (it.ea_reg == eau_pkg::SUB_IMM && it.size == eau_pkg::SIZE_NONE) begin
          r.status = eau_pkg::ST_SIZE;
        end else if (it.fault) begin
          r.status = eau_pkg::ST_FAULT;
        end else begin
          r.ext_bytes = 3'd2;
          case (it.ea_reg)
            eau_pkg::SUB_ABSW: r.address = w0x;
            eau_pkg::SUB_ABSL: begin
              r.address = it.ext;
              r.ext_bytes = 3'd4;
            end
            eau_pkg::SUB_PCDISP: r.address = it.pc + w0x;
            eau_pkg::SUB_PCINDEX: r.address = index_sum(it.pc, w0);
            default: begin
              r.status = eau_pkg::ST_IMM;
              if (it.size == eau_pkg::SIZE_BYTE) begin
                r.immediate = {24'd0, w0[7:0]};
              end else if (it.size == eau_pkg::SIZE_WORD) begin
                r.immediate = {16'd0, w0};
              end else begin
                r.immediate = it.ext;
                r.ext_bytes = 3'd4;
              end
            end
          endcase
        end
      end
    endcase
    return r;
  endfunction

  function automatic stim_row_t ea_row(input logic [2:0] mode, input logic [2:0] sub,
                                       input logic [1:0] size, input logic [31:0] pc,
                                       input logic [31:0] ext, input logic fault);
    stim_row_t s;
    s.item.cmd = CMD_EA;
    s.item.widx = '0;
    s.item.wval = '0;
    s.item.mode = mode;
    s.item.ea_reg = sub;
    s.item.size = size;
    s.item.pc = pc;
    s.item.ext = ext;
    s.item.fault = fault;
    s.fixed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  // a register write always answers with an all-zero result
  function automatic stim_row_t write_row(input logic [3:0] idx, input logic [31:0] val);
    stim_row_t s;
    s = ea_row(eau_pkg::MODE_DN, 3'd0, eau_pkg::SIZE_BYTE, '0, '0, 1'b0);
    s.item.cmd = eau_pkg::CMD_WRITE;
    s.item.widx = idx;
    s.item.wval = val;
    s.fixed = 1'b1;
    return s;
  endfunction

  function automatic stim_row_t with_want(input stim_row_t s, input eau_pkg::status_e st,
                                          input logic [31:0] addr, input logic [31:0] imm,
                                          input logic [2:0] nb);
    stim_row_t t;
    t = s;
    t.fixed = 1'b1;
    t.want.status = st;
    t.want.address = addr;
    t.want.immediate = imm;
    t.want.ext_bytes = nb;
    return t;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic ea_item_t random_item();
    stim_row_t s;
    if ($urandom_range(0, 3) == 0) begin
      s = write_row(4'($urandom_range(0, 15)), pick_word());
    end else begin
      s = ea_row(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                 2'($urandom_range(0, 3)), pick_word(), pick_word(),
                 $urandom_range(0, 7) == 0);
    end
    return s.item;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0d ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      err_count++;
    end
  endfunction

  task automatic send_beat(input ea_item_t it, input bit fixed, input eau_pkg::res_t want);
    int unsigned   gap;
    eau_pkg::res_t r;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    cmd_i <= it.cmd;
    write_index_i <= it.widx;
    write_value_i <= it.wval;
    ea_mode_i <= it.mode;
    ea_reg_i <= it.ea_reg;
    operand_size_i <= it.size;
    pc_value_i <= it.pc;
    ext_words_i <= it.ext;
    fetch_fault_i <= it.fault;
    do @(posedge clk_i); while (full);
    r = predict_ea(it);
    pending_q.push_back(fixed ? want : r);
  endtask

  initial begin : result_side
    int unsigned   gap;
    eau_pkg::res_t want;
    pop = 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 12);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = 80;
      end
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if (pending_q.size() == 0) begin
        $display("%0d ns: unexpected beat, status %0d address %0h", $time, status_o, address_o);
        err_count++;
      end else begin
        want = pending_q.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("address", want.address, address_o);
        check_field("immediate", want.immediate, immediate_o);
        check_field("ext_bytes", 32'(want.ext_bytes), 32'(ext_bytes_o));
      end
    end
  end

  initial begin : stimulus
    rst_ni = 1'b0;
    push = 1'b0;
    cmd_i = eau_pkg::CMD_WRITE;
    write_index_i = '0;
    write_value_i = '0;
    ea_mode_i = eau_pkg::MODE_DN;
    ea_reg_i = '0;
    operand_size_i = eau_pkg::SIZE_BYTE;
    pc_value_i = '0;
    ext_words_i = '0;
    fetch_fault_i = 1'b0;
    err_count = 0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    hold_off_req = 1'b0;
    foreach (gpr[i]) gpr[i] = '0;

    rows.push_back(with_want(ea_row(eau_pkg::MODE_IND, 3'd0, SIZE_LONG, '0, '0, 1'b0),
                             eau_pkg::ST_MEM, '0, '0, 3'd0));
    rows.push_back(with_want(ea_row(eau_pkg::MODE_DN, 3'd7, eau_pkg::SIZE_NONE, '1, '1, 1'b1),
                             eau_pkg::ST_REG, '0, '0, 3'd0));
    rows.push_back(with_want(ea_row(eau_pkg::MODE_AN, 3'd3, eau_pkg::SIZE_BYTE, '0, '1, 1'b0),
                             eau_pkg::ST_REG, '0, '0, 3'd0));
    rows.push_back(with_want(ea_row(eau_pkg::MODE_EXT, 3'd5, eau_pkg::SIZE_WORD, '0, '0, 1'b0),
                             eau_pkg::ST_UNSUP, '0, '0, 3'd0));
    rows.push_back(with_want(ea_row(eau_pkg::MODE_EXT, 3'd7, eau_pkg::SIZE_NONE, '1, '1, 1'b1),
                             eau_pkg::ST_UNSUP, '0, '0, 3'd0));
    rows.push_back(with_want(ea_row(eau_pkg::MODE_EXT, eau_pkg::SUB_IMM, eau_pkg::SIZE_NONE,
                                    '0, '1, 1'b1),
                             eau_pkg::ST_SIZE, '0, '0, 3'd0));
    rows.push_back(with_want(ea_row(eau_pkg::MODE_POSTINC, 3'd2, eau_pkg::SIZE_NONE,
                                    '0, '0, 1'b0),
                             eau_pkg::ST_SIZE, '0, '0, 3'd0));
    rows.push_back(with_want(ea_row(eau_pkg::MODE_PREDEC, 3'd2, eau_pkg::SIZE_NONE,
                                    '0, '0, 1'b0),
                             eau_pkg::ST_SIZE, '0, '0, 3'd0));
    rows.push_back(with_want(ea_row(eau_pkg::MODE_DISP, 3'd1, eau_pkg::SIZE_WORD, '0, '1, 1'b1),
                             eau_pkg::ST_FAULT, '0, '0, 3'd0));
    rows.push_back(with_want(ea_row(eau_pkg::MODE_EXT, eau_pkg::SUB_PCINDEX, SIZE_LONG,
                                    '1, '0, 1'b1),
                             eau_pkg::ST_FAULT, '0, '0, 3'd0));
    rows.push_back(with_want(ea_row(eau_pkg::MODE_EXT, eau_pkg::SUB_ABSW, eau_pkg::SIZE_BYTE,
                                    '0, 32'h8000_1234, 1'b0),
                             eau_pkg::ST_MEM, 32'hffff_8000, '0, 3'd2));
    rows.push_back(with_want(ea_row(eau_pkg::MODE_EXT, eau_pkg::SUB_ABSL, eau_pkg::SIZE_WORD,
                                    '0, '1, 1'b0),
                             eau_pkg::ST_MEM, '1, '0, 3'd4));
    rows.push_back(with_want(ea_row(eau_pkg::MODE_EXT, eau_pkg::SUB_IMM, eau_pkg::SIZE_BYTE,
                                    '0, 32'habcd_1234, 1'b0),
                             eau_pkg::ST_IMM, '0, 32'h0000_00cd, 3'd2));
    rows.push_back(with_want(ea_row(eau_pkg::MODE_EXT, eau_pkg::SUB_IMM, eau_pkg::SIZE_WORD,
                                    '0, 32'habcd_1234, 1'b0),
                             eau_pkg::ST_IMM, '0, 32'h0000_abcd, 3'd2));
    rows.push_back(with_want(ea_row(eau_pkg::MODE_EXT, eau_pkg::SUB_IMM, SIZE_LONG,
                                    '0, 32'habcd_1234, 1'b0),
                             eau_pkg::ST_IMM, '0, 32'habcd_1234, 3'd4));
    rows.push_back(write_row(4'd8, 32'hffff_ffff));
    rows.push_back(write_row(4'd7, 32'h0001_8000));
    rows.push_back(write_row(4'd15, 32'h7fff_ffff));
    rows.push_back(ea_row(eau_pkg::MODE_POSTINC, 3'd0, SIZE_LONG, '0, '0, 1'b0));
    rows.push_back(ea_row(eau_pkg::MODE_PREDEC, 3'd0, eau_pkg::SIZE_BYTE, '0, '0, 1'b0));
    rows.push_back(ea_row(eau_pkg::MODE_PREDEC, 3'd0, eau_pkg::SIZE_WORD, '0, '0, 1'b0));
    rows.push_back(ea_row(eau_pkg::MODE_DISP, 3'd7, SIZE_LONG, '0, 32'h7fff_0000, 1'b0));
    rows.push_back(ea_row(eau_pkg::MODE_INDEX, 3'd7, eau_pkg::SIZE_WORD, '0, 32'h7080_0000,
                          1'b0));
    rows.push_back(ea_row(eau_pkg::MODE_INDEX, 3'd0, eau_pkg::SIZE_BYTE, '0, 32'hffff_0000,
                          1'b0));
    rows.push_back(ea_row(eau_pkg::MODE_EXT, eau_pkg::SUB_PCDISP, eau_pkg::SIZE_WORD, '1,
                          32'h0001_0000, 1'b0));
    rows.push_back(ea_row(eau_pkg::MODE_EXT, eau_pkg::SUB_PCINDEX, SIZE_LONG, '0,
                          32'h7f7f_0000, 1'b0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) send_beat(rows[i].item, rows[i].fixed, rows[i].want);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) hold_off_req = 1'b1;
      if (n == 650 && pending_q.size() != 0) begin
        push <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk_i);
      end
      send_beat(random_item(), 1'b0, '0);
    end

    push <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
